### sv/ncc_pkg.sv
// ncc_pkg: shared types and constants for the nearest cluster cache
// used by ncc_div, nearest_cluster_cache_unit and the testbench; no dependencies
package ncc_pkg;

   // default cache size
   localparam int CACHE_DEPTH_DEF = 32;

   // field widths
   localparam int COORD_W  = 24;
   localparam int HITS_W   = 16;
   localparam int STAMP_W  = 32;
   localparam int SLOT_W   = 6;
   localparam int REMOVE_W = 7;
   localparam int RADIUS_W = 16;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // running mean arithmetic
   localparam int NUM_W = 42;
   localparam int DIV_W = HITS_W + 1;
   localparam int SQ_W  = 2 * (COORD_W + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_RADIUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EXPIRY_TIME  = 1'b1;

   // register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd64;
   localparam logic [STAMP_W-1:0]  EXPIRY_RST = 32'd5000;
   localparam logic [HITS_W-1:0]   HITS_MAX   = 16'hFFFF;

   // result status codes
   localparam logic [1:0] STAT_MATCH  = 2'd0;
   localparam logic [1:0] STAT_INSERT = 2'd1;
   localparam logic [1:0] STAT_DROP   = 2'd2;
   localparam logic [1:0] STAT_DUMP   = 2'd3;

   // input opcodes
   localparam logic OP_DETECT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   // one cache entry as stored in the memory
   typedef struct packed {
      logic [STAMP_W-1:0]        stamp;
      logic [HITS_W-1:0]         hits;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } entry_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SQR, S_CMP, S_DECIDE, S_MRD, S_MCAP, S_DSTART,
      S_DWAIT, S_WRITE, S_SWRD, S_SWCHK, S_SWEND, S_RESULT, S_DRD, S_DOUT
   } state_type;

endpackage

### sv/ncc_ram.sv
// ncc_ram: generic single write, single read memory with registered read
// no dependencies
module ncc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ncc_div.sv
// ncc_div: iterative unsigned restoring divider, one quotient bit per cycle
// depends on ncc_pkg for default widths
module ncc_div #(
   parameter int NW = ncc_pkg::NUM_W,
   parameter int DW = ncc_pkg::DIV_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      rem_sh;
   logic [DW:0]      rem_sub;
   logic             bit_q;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      bit_q   = (rem_sh >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], bit_q};
         rem_in = bit_q ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/nearest_cluster_cache_unit.sv
// Nearest cluster cache. Entries live in one memory (x, y, z, hits, stamp per
// entry); a sequencer walks it one entry at a time. A detection reads, squares
// and compares every stored entry for the nearest search; a match then runs three
// parallel 42-step dividers to form the running mean; at frame end an expiry sweep
// reads and checks every entry. A dump reads and sends each listed entry in turn.
// The single memory read port sets this entry-by-entry order. Items are taken
// one at a time; the result register lets the next item enter while a result
// waits.
module nearest_cluster_cache_unit #(
   parameter int CACHE_DEPTH = ncc_pkg::CACHE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = point_x, point_y, point_z, time_now (low to high)
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ncc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,   // opcode
   input  logic                             req_tlast,   // frame_end
   // response: tdata = slot, mean_x, mean_y, mean_z, hits, removed, zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ncc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ncc_pkg::RSP_USER_W-1:0]   rsp_tuser,   // status, entry_valid
   output logic                             rsp_tlast,   // last
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ncc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ncc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ncc_pkg::*;

   localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int CW = $clog2(CACHE_DEPTH + 1);
   localparam int EW = $bits(entry_type);

   state_type state_ff, state_in;

   logic [RADIUS_W-1:0]     radius_ff;
   logic [STAMP_W-1:0]      expiry_ff;
   logic [2*RADIUS_W-1:0]   lim_ff, lim_in;
   logic [CW-1:0]           total_ff, total_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [AW-1:0]           wptr_ff, wptr_in;
   logic [AW-1:0]           slot_ff, slot_in;
   logic [AW-1:0]           newslot_ff, newslot_in;
   logic                    found_ff, found_in;
   logic [SQ_W:0]           best_ff, best_in;
   logic [REMOVE_W-1:0]     removed_ff, removed_in;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [STAMP_W-1:0]      now_ff;
   logic                    fe_ff;
   logic signed [SQ_W-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [HITS_W-1:0]       n_ff, n_in;
   logic signed [NUM_W-1:0] numx_ff, numx_in, numy_ff, numy_in, numz_ff, numz_in;
   entry_type               res_ff, res_in;
   logic [1:0]              status_ff, status_in;
   logic                    rvalid_ff, rvalid_in;
   logic                    accept;

   // output register
   logic                    out_vld_ff, out_vld_in;
   logic [SLOT_W-1:0]       o_slot_ff, o_slot_in;
   entry_type               o_ent_ff, o_ent_in;
   logic [1:0]              o_stat_ff, o_stat_in;
   logic                    o_valid_ff, o_valid_in;
   logic [REMOVE_W-1:0]     o_rem_ff, o_rem_in;
   logic                    o_last_ff, o_last_in;
   logic                    out_free;

   // memory port
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   entry_type               wr_data;
   logic [AW-1:0]           rd_addr;
   logic [EW-1:0]           rd_word;
   entry_type               rd_ent;

   // divider port
   logic                    div_start;
   logic [DIV_W-1:0]        div_d;
   logic [HITS_W-1:0]       half;
   logic [NUM_W-1:0]        dend_x, dend_y, dend_z;
   logic                    dx_done, dy_done, dz_done;
   logic [NUM_W-1:0]        qx, qy, qz;

   logic signed [COORD_W:0] dx, dy;
   logic [SQ_W:0]           d2;
   logic [STAMP_W-1:0]      age;
   logic                    last_idx;

   assign rd_ent    = entry_type'(rd_word);
   assign accept    = req_tvalid & req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free  = ~out_vld_ff | rsp_tready;
   assign csr_ready = 1'b1;
   assign last_idx  = (idx_ff + 1'b1 == total_ff);

   ncc_ram #(.WIDTH(EW), .DEPTH(CACHE_DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // rounding: add half the divisor to the magnitude
   assign div_d  = DIV_W'(n_ff) + 1'b1;
   assign half   = div_d[DIV_W-1:1];
   assign dend_x = (numx_ff[NUM_W-1] ? NUM_W'(-numx_ff) : NUM_W'(numx_ff)) + NUM_W'(half);
   assign dend_y = (numy_ff[NUM_W-1] ? NUM_W'(-numy_ff) : NUM_W'(numy_ff)) + NUM_W'(half);
   assign dend_z = (numz_ff[NUM_W-1] ? NUM_W'(-numz_ff) : NUM_W'(numz_ff)) + NUM_W'(half);

   ncc_div #(.NW(NUM_W), .DW(DIV_W)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dend_x),
      .divisor(div_d), .done(dx_done), .quotient(qx));
   ncc_div #(.NW(NUM_W), .DW(DIV_W)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dend_y),
      .divisor(div_d), .done(dy_done), .quotient(qy));
   ncc_div #(.NW(NUM_W), .DW(DIV_W)) u_div_z (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dend_z),
      .divisor(div_d), .done(dz_done), .quotient(qz));

   // distance terms from the entry just read
   assign dx  = (COORD_W+1)'(rd_ent.x) - (COORD_W+1)'(px_ff);
   assign dy  = (COORD_W+1)'(rd_ent.y) - (COORD_W+1)'(py_ff);
   assign d2  = (SQ_W+1)'(unsigned'(sqx_ff)) + (SQ_W+1)'(unsigned'(sqy_ff));
   assign age = now_ff - rd_ent.stamp;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_DUMP) begin
                  state_in = (total_ff == '0) ? S_RESULT : S_DRD;
               end else begin
                  state_in = (total_ff == '0) ? S_DECIDE : S_SCAN;
               end
            end
         end
         S_SCAN:   state_in = S_SQR;
         S_SQR:    state_in = S_CMP;
         S_CMP:    state_in = last_idx ? S_DECIDE : S_SCAN;
         S_DECIDE: begin
            if (found_ff) state_in = S_MRD;
            else          state_in = fe_ff ? S_SWRD : S_RESULT;
         end
         S_MRD:    state_in = S_MCAP;
         S_MCAP:   state_in = S_DSTART;
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT:  state_in = dx_done ? S_WRITE : S_DWAIT;
         S_WRITE:  state_in = fe_ff ? S_SWRD : S_RESULT;
         S_SWRD:   state_in = S_SWCHK;
         S_SWCHK:  state_in = last_idx ? S_SWEND : S_SWRD;
         S_SWEND:  state_in = S_RESULT;
         S_RESULT: state_in = out_free ? S_IDLE : S_RESULT;
         S_DRD:    state_in = S_DOUT;
         S_DOUT: begin
            if (out_free) state_in = last_idx ? S_IDLE : S_DRD;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control per state
   always_comb begin
      lim_in     = lim_ff;
      total_in   = total_ff;
      idx_in     = idx_ff;
      wptr_in    = wptr_ff;
      slot_in    = slot_ff;
      newslot_in = newslot_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      removed_in = removed_ff;
      sqx_in     = sqx_ff;
      sqy_in     = sqy_ff;
      n_in       = n_ff;
      numx_in    = numx_ff;
      numy_in    = numy_ff;
      numz_in    = numz_ff;
      res_in     = res_ff;
      status_in  = status_ff;
      rvalid_in  = rvalid_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = res_ff;
      rd_addr    = idx_ff[AW-1:0];
      div_start  = 1'b0;
      out_vld_in = out_vld_ff & ~rsp_tready;
      o_slot_in  = o_slot_ff;
      o_ent_in   = o_ent_ff;
      o_stat_in  = o_stat_ff;
      o_valid_in = o_valid_ff;
      o_rem_in   = o_rem_ff;
      o_last_in  = o_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lim_in     = radius_ff * radius_ff;
               idx_in     = '0;
               found_in   = 1'b0;
               removed_in = '0;
               slot_in    = '0;
               res_in     = '0;
               rvalid_in  = 1'b0;
               status_in  = STAT_DUMP;
            end
         end
         S_SQR: begin
            sqx_in = dx * dx;
            sqy_in = dy * dy;
         end
         S_CMP: begin
            if (d2 < (SQ_W+1)'(lim_ff) && (!found_ff || d2 < best_ff)) begin
               found_in = 1'b1;
               best_in  = d2;
               slot_in  = idx_ff[AW-1:0];
            end
            idx_in = idx_ff + 1'b1;
         end
         S_DECIDE: begin
            rvalid_in = 1'b1;
            res_in.x  = px_ff;
            res_in.y  = py_ff;
            res_in.z  = pz_ff;
            res_in.stamp = now_ff;
            if (found_ff) begin
               status_in = STAT_MATCH;
            end else if (total_ff < CW'(CACHE_DEPTH)) begin
               status_in   = STAT_INSERT;
               res_in.hits = HITS_W'(1);
               slot_in     = total_ff[AW-1:0];
               wr_en       = 1'b1;
               wr_addr     = total_ff[AW-1:0];
               wr_data     = res_in;
               total_in    = total_ff + 1'b1;
            end else begin
               status_in   = STAT_DROP;
               res_in.hits = '0;
               slot_in     = '0;
            end
            idx_in     = '0;
            wptr_in    = '0;
            newslot_in = slot_in;
         end
         S_MRD: begin
            rd_addr = slot_ff;
         end
         S_MCAP: begin
            n_in    = rd_ent.hits;
            numx_in = NUM_W'(rd_ent.x * $signed({1'b0, rd_ent.hits})) + NUM_W'(px_ff);
            numy_in = NUM_W'(rd_ent.y * $signed({1'b0, rd_ent.hits})) + NUM_W'(py_ff);
            numz_in = NUM_W'(rd_ent.z * $signed({1'b0, rd_ent.hits})) + NUM_W'(pz_ff);
         end
         S_DSTART: begin
            div_start = 1'b1;
         end
         S_WRITE: begin
            res_in.x = numx_ff[NUM_W-1] ? -COORD_W'(qx) : COORD_W'(qx);
            res_in.y = numy_ff[NUM_W-1] ? -COORD_W'(qy) : COORD_W'(qy);
            res_in.z = numz_ff[NUM_W-1] ? -COORD_W'(qz) : COORD_W'(qz);
            res_in.hits = (n_ff != HITS_MAX) ? n_ff + 1'b1 : n_ff;
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            wr_data = res_in;
         end
         S_SWCHK: begin
            if (age > expiry_ff) begin
               removed_in = removed_ff + 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff;
               wr_data = rd_ent;
               if (idx_ff[AW-1:0] == slot_ff) newslot_in = wptr_ff;
               wptr_in = wptr_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         S_SWEND: begin
            // a full cache with every entry kept wraps the write pointer
            total_in = total_ff - CW'(removed_ff);
            if (status_ff != STAT_DROP) slot_in = newslot_ff;
         end
         S_RESULT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               o_slot_in  = SLOT_W'(slot_ff);
               o_ent_in   = res_ff;
               o_stat_in  = status_ff;
               o_valid_in = rvalid_ff;
               o_rem_in   = removed_ff;
               o_last_in  = 1'b1;
            end
         end
         S_DOUT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               o_slot_in  = SLOT_W'(idx_ff);
               o_ent_in   = rd_ent;
               o_stat_in  = STAT_DUMP;
               o_valid_in = 1'b1;
               o_rem_in   = '0;
               o_last_in  = last_idx;
               idx_in     = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         out_vld_ff <= 1'b0;
         radius_ff  <= RADIUS_RST;
         expiry_ff  <= EXPIRY_RST;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid && csr_index == REG_MATCH_RADIUS) radius_ff <= csr_data[RADIUS_W-1:0];
         if (csr_valid && csr_index == REG_EXPIRY_TIME)  expiry_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff  <= req_tdata[COORD_W-1:0];
         py_ff  <= req_tdata[2*COORD_W-1:COORD_W];
         pz_ff  <= req_tdata[3*COORD_W-1:2*COORD_W];
         now_ff <= req_tdata[3*COORD_W+STAMP_W-1:3*COORD_W];
         fe_ff  <= req_tlast;
      end
      lim_ff     <= lim_in;
      idx_ff     <= idx_in;
      wptr_ff    <= wptr_in;
      slot_ff    <= slot_in;
      newslot_ff <= newslot_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      removed_ff <= removed_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      n_ff       <= n_in;
      numx_ff    <= numx_in;
      numy_ff    <= numy_in;
      numz_ff    <= numz_in;
      res_ff     <= res_in;
      status_ff  <= status_in;
      rvalid_ff  <= rvalid_in;
      o_slot_ff  <= o_slot_in;
      o_ent_ff   <= o_ent_in;
      o_stat_ff  <= o_stat_in;
      o_valid_ff <= o_valid_in;
      o_rem_ff   <= o_rem_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, o_rem_ff, o_ent_ff.hits, o_ent_ff.z, o_ent_ff.y,
                        o_ent_ff.x, o_slot_ff};
   assign rsp_tuser  = {o_valid_ff, o_stat_ff};
   assign rsp_tlast  = o_last_ff;

   // entry count never passes the cache size
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(CACHE_DEPTH))
      else $error("entry count above cache size");

   // compaction never writes ahead of the read position
   a_wptr_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWCHK |-> CW'(wptr_ff) <= idx_ff)
      else $error("compaction write pointer ahead of read pointer");

   // a match always points at a stored entry
   a_match_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MRD |-> CW'(slot_ff) < total_ff)
      else $error("matched slot beyond entry count");

   // dividers finish together and only while waited on
   a_div_sync: assert property (@(posedge clock) disable iff (reset)
      dx_done |-> (dy_done && dz_done && state_ff == S_DWAIT))
      else $error("divider completion out of step");

endmodule

### sim/testbench.sv
// testbench: checks nearest_cluster_cache_unit against its own cache predictor
// depends on ncc_pkg and nearest_cluster_cache_unit
`timescale 1ns / 100ps

module testbench;
   import ncc_pkg::*;

   localparam int DEPTH = 32;
   localparam int IDLE_LIMIT = 20000;

   // expected result item
   typedef struct {
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] mx;
      logic signed [COORD_W-1:0] my;
      logic signed [COORD_W-1:0] mz;
      logic [HITS_W-1:0]         hits;
      logic [1:0]                status;
      logic                      valid;
      logic [REMOVE_W-1:0]       removed;
      logic                      last;
   } cluster_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // point_x, point_y, point_z, time_now
   logic req_tuser = 1'b0;                  // opcode
   logic req_tlast = 1'b0;                  // frame_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // slot, mean_x, mean_y, mean_z, hits, removed
   logic [RSP_USER_W-1:0] rsp_tuser;        // status, entry_valid
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic signed [COORD_W-1:0] pc_x [DEPTH];
   logic signed [COORD_W-1:0] pc_y [DEPTH];
   logic signed [COORD_W-1:0] pc_z [DEPTH];
   logic [HITS_W-1:0] pc_hits [DEPTH];
   logic [STAMP_W-1:0] pc_stamp [DEPTH];
   int pc_total = 0;
   logic [RADIUS_W-1:0] pc_radius = RADIUS_RST;
   logic [STAMP_W-1:0] pc_expiry = EXPIRY_RST;

   cluster_result_type pending_results[$];
   int send_idle = 0;
   int recv_stall = 0;
   int errors = 0;
   int quiet_cycles = 0;
   logic [31:0] clock_ms = 0;

   nearest_cluster_cache_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // running mean, rounded half away from zero
   function automatic logic signed [COORD_W-1:0] running_mean(
      input logic signed [COORD_W-1:0] prev, input logic [HITS_W-1:0] n,
      input logic signed [COORD_W-1:0] pnt);
      longint num, d;
      num = longint'(prev) * longint'(n) + longint'(pnt);
      d = longint'(n) + 1;
      if (num >= 0) return COORD_W'((num + d / 2) / d);
      return COORD_W'(-((-num + d / 2) / d));
   endfunction

   // predict the results of one item
   task automatic predict_item(input logic op, input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic signed [COORD_W-1:0] pz,
                               input logic [31:0] now, input logic fend);
      cluster_result_type r;
      longint dx, dy, d2, best, lim;
      int slot, w, newslot, removed;
      logic found;
      logic [1:0] st;
      logic [31:0] age;
      found = 0; best = 0; slot = 0; removed = 0;
      if (op == OP_DUMP) begin
         if (pc_total == 0) begin
            r = '{0, 0, 0, 0, 0, STAT_DUMP, 0, 0, 1};
            pending_results = {pending_results, r};
         end
         for (int i = 0; i < pc_total; i++) begin
            r = '{SLOT_W'(i), pc_x[i], pc_y[i], pc_z[i], pc_hits[i], STAT_DUMP, 1, 0,
                  i == pc_total - 1};
            pending_results = {pending_results, r};
         end
         return;
      end
      lim = longint'(pc_radius) * longint'(pc_radius);
      for (int i = 0; i < pc_total; i++) begin
         dx = longint'(pc_x[i]) - longint'(px);
         dy = longint'(pc_y[i]) - longint'(py);
         d2 = dx * dx + dy * dy;
         if (d2 < lim && (!found || d2 < best)) begin
            found = 1; best = d2; slot = i;
         end
      end
      if (found) begin
         pc_x[slot] = running_mean(pc_x[slot], pc_hits[slot], px);
         pc_y[slot] = running_mean(pc_y[slot], pc_hits[slot], py);
         pc_z[slot] = running_mean(pc_z[slot], pc_hits[slot], pz);
         if (pc_hits[slot] != HITS_MAX) pc_hits[slot]++;
         pc_stamp[slot] = now;
         st = STAT_MATCH;
      end else if (pc_total < DEPTH) begin
         slot = pc_total;
         pc_x[slot] = px; pc_y[slot] = py; pc_z[slot] = pz;
         pc_hits[slot] = 1; pc_stamp[slot] = now;
         pc_total++;
         st = STAT_INSERT;
      end else begin
         st = STAT_DROP;
      end
      // expiry sweep with compaction
      if (fend) begin
         newslot = slot; w = 0;
         for (int i = 0; i < pc_total; i++) begin
            age = now - pc_stamp[i];
            if (age > pc_expiry) begin
               removed++;
               continue;
            end
            if (i == slot) newslot = w;
            pc_x[w] = pc_x[i]; pc_y[w] = pc_y[i]; pc_z[w] = pc_z[i];
            pc_hits[w] = pc_hits[i]; pc_stamp[w] = pc_stamp[i];
            w++;
         end
         pc_total = w;
         if (st != STAT_DROP) slot = newslot;
      end
      if (st == STAT_DROP) r = '{0, px, py, pz, 0, STAT_DROP, 1, REMOVE_W'(removed), 1};
      else r = '{SLOT_W'(slot), pc_x[slot], pc_y[slot], pc_z[slot], pc_hits[slot], st, 1,
                 REMOVE_W'(removed), 1};
      pending_results = {pending_results, r};
   endtask

   // send one item, with random sender gaps; valid stays up until the next gap
   task automatic send_item(input logic op, input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic signed [COORD_W-1:0] pz,
                            input logic [31:0] now, input logic fend);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tlast <= fend;
      req_tdata <= {now, pz, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(op, px, py, pz, now, fend);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_MATCH_RADIUS) pc_radius = val[RADIUS_W-1:0];
      else pc_expiry = val;
      @(posedge clock);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      cluster_result_type e;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > IDLE_LIMIT) begin
            $display("nearest_cluster_cache_unit: mismatch");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t expected no result, actual data %h user %b last %b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_tdata != {3'd0, e.removed, e.hits, e.mz, e.my, e.mx, e.slot}
                   || rsp_tuser != {e.valid, e.status} || rsp_tlast != e.last) begin
                  $display("%0t expected slot %0d x %0d y %0d z %0d hits %0d st %0d v %0d rm %0d last %0d",
                           $time, e.slot, e.mx, e.my, e.mz, e.hits, e.status, e.valid,
                           e.removed, e.last);
                  $display("%0t actual data %h user %b last %b", $time, rsp_tdata,
                           rsp_tuser, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // directed: extremes, match, mean, sweep, dump
   task automatic test_directed();
      send_item(OP_DUMP, 0, 0, 0, 0, 0);
      send_item(OP_DETECT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 100, 0);
      send_item(OP_DETECT, 24'sh800000, 24'sh800000, 24'sh800000, 100, 0);
      send_item(OP_DETECT, 24'sh7FFFF0, 24'sh7FFFF0, 24'sh800000, 110, 0);
      send_item(OP_DETECT, 24'sh800005, 24'sh800001, 24'sh7FFFFF, 120, 0);
      send_item(OP_DETECT, 10, 10, -3, 130, 0);
      send_item(OP_DETECT, 11, 10, -4, 140, 0);
      send_item(OP_DETECT, -20, 0, 5, 150, 0);
      send_item(OP_DUMP, 0, 0, 0, 0, 0);
      send_item(OP_DETECT, 0, 0, 0, 32'hFFFFFFFF, 1);
      send_item(OP_DUMP, 24'sh7FFFFF, -1, -1, 32'hFFFFFFFF, 1);
      drain();
   endtask

   task automatic test_full_cache();
      write_reg(REG_MATCH_RADIUS, 0);
      write_reg(REG_EXPIRY_TIME, 32'hFFFFFFFF);
      for (int i = 0; i < DEPTH + 2; i++) send_item(OP_DETECT, i * 300, -i, i, 200, 0);
      send_item(OP_DETECT, 5, 5, 5, 201, 1);
      drain();
      write_reg(REG_MATCH_RADIUS, 16'hFFFF);
      write_reg(REG_EXPIRY_TIME, 0);
      send_item(OP_DETECT, 1, 2, 3, 300, 1);
      send_item(OP_DUMP, 0, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_random(input int count, input int gap, input int stall);
      logic signed [COORD_W-1:0] px, py;
      send_idle = gap;
      recv_stall = stall;
      for (int i = 0; i < count; i++) begin
         clock_ms += $urandom_range(300);
         if ($urandom_range(9) < 7) begin
            px = $urandom_range(600) - 300;
            py = $urandom_range(600) - 300;
         end else begin
            px = $urandom; py = $urandom;
         end
         if ($urandom_range(11) == 0)
            send_item(OP_DUMP, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            send_item(OP_DETECT, px, py, $urandom, clock_ms, $urandom_range(4) == 0);
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_cache();
      write_reg(REG_MATCH_RADIUS, 80);
      write_reg(REG_EXPIRY_TIME, 700);
      test_random(15, 0, 0);
      write_reg(REG_MATCH_RADIUS, 200);
      test_random(15, 59, 0);
      write_reg(REG_EXPIRY_TIME, 2000);
      test_random(15, 0, 59);
      test_random(15, 13, 13);
      if (errors == 0) $display("nearest_cluster_cache_unit: match");
      else $display("nearest_cluster_cache_unit: mismatch");
      $finish;
   end
endmodule
